FILE: rtl/lec_pkg.sv
// Shared types and constants for the line editor core.
// Holds the item and result payload structs, edit plan, causes and character codes.
// No dependencies.
`default_nettype none

package lec_pkg;

	localparam int CFG_IDX_W = 1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       read_failed;
	} lec_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last;
		logic [1:0] end_cause;
		logic [6:0] line_length;
	} lec_out_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_LF,
		OP_SHL,
		OP_INS
	} lec_op_t;

	typedef struct packed {
		lec_op_t    op;
		logic       skip;
		logic       emit;
		logic [1:0] cause;
	} lec_plan_t;

	localparam logic [1:0] CAUSE_NEWLINE = 2'd0;
	localparam logic [1:0] CAUSE_QUIT    = 2'd1;
	localparam logic [1:0] CAUSE_FULL    = 2'd2;
	localparam logic [1:0] CAUSE_ERROR   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUIT     = 1'd1;

	localparam logic [6:0] CAPACITY_RESET = 7'd64;
	localparam logic [7:0] QUIT_RESET     = 8'd28;

	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_ESC   = 8'd27;
	localparam logic [7:0] CH_DEL   = 8'd127;
	localparam logic [7:0] CH_CSI   = 8'd155;
	localparam logic [7:0] CH_UP    = 8'h41;
	localparam logic [7:0] CH_DOWN  = 8'h42;
	localparam logic [7:0] CH_RIGHT = 8'h43;
	localparam logic [7:0] CH_LEFT  = 8'h44;

endpackage

`default_nettype wire

FILE: rtl/lec_decode.sv
// Character decoder for the line editor core.
// Turns one received item and the cursor state into an edit plan and next cursor state.
// Depends on lec_pkg.
`default_nettype none

module lec_decode #(
	parameter int LINE_MAX = 64
) (
	input  var lec_pkg::lec_in_t                 item,
	input  var logic [7:0]                       quit_char,
	input  var logic [6:0]                       line_capacity,
	input  var logic [$clog2(LINE_MAX+1)-1:0]    cur,
	input  var logic [$clog2(LINE_MAX+1)-1:0]    len,
	input  var logic                             esc,
	output lec_pkg::lec_plan_t                   plan,
	output logic [$clog2(LINE_MAX+1)-1:0]        cur_nx,
	output logic [$clog2(LINE_MAX+1)-1:0]        len_nx,
	output logic                                 esc_nx
);

	localparam int PW = $clog2(LINE_MAX + 1);
	localparam logic [PW-1:0] LMAX  = PW'(LINE_MAX);
	localparam logic [6:0]    LMAX7 = 7'(LINE_MAX);

	logic [7:0] z;
	logic [6:0] eff_cap;
	logic       moved;

	assign z = item.data_byte;

	always_comb begin
		if (line_capacity == 7'd0) begin
			eff_cap = 7'd1;
		end else if (line_capacity > LMAX7) begin
			eff_cap = LMAX7;
		end else begin
			eff_cap = line_capacity;
		end
	end

	always_comb begin
		plan.op    = lec_pkg::OP_NONE;
		plan.skip  = 1'b0;
		plan.emit  = 1'b0;
		plan.cause = lec_pkg::CAUSE_FULL;
		cur_nx     = cur;
		len_nx     = len;
		esc_nx     = esc;
		moved      = 1'b0;
		if (item.read_failed) begin
			plan.emit  = 1'b1;
			plan.cause = lec_pkg::CAUSE_ERROR;
			cur_nx     = '0;
			len_nx     = '0;
			esc_nx     = 1'b0;
		end else if (z == quit_char) begin
			plan.emit  = 1'b1;
			plan.cause = lec_pkg::CAUSE_QUIT;
		end else if (z == lec_pkg::CH_LF || z == lec_pkg::CH_CR) begin
			plan.emit  = 1'b1;
			plan.cause = lec_pkg::CAUSE_NEWLINE;
			if (len < LMAX) begin
				plan.op = lec_pkg::OP_LF;
				len_nx  = len + PW'(1);
			end
		end else begin
			if (z == lec_pkg::CH_ESC || z == lec_pkg::CH_CSI) begin
				esc_nx = 1'b1;
			end else if (z == lec_pkg::CH_BS) begin
				if (cur != '0) begin
					plan.op = lec_pkg::OP_SHL;
					cur_nx  = cur - PW'(1);
					len_nx  = len - PW'(1);
				end
			end else if (z == lec_pkg::CH_DEL) begin
				if (cur < len) begin
					plan.op   = lec_pkg::OP_SHL;
					plan.skip = 1'b1;
					len_nx    = len - PW'(1);
				end
			end else begin
				if (esc) begin
					esc_nx = 1'b0;
					if (z == lec_pkg::CH_RIGHT || z == lec_pkg::CH_UP) begin
						moved = 1'b1;
						if (cur < len) begin
							cur_nx = cur + PW'(1);
						end
					end else if (z == lec_pkg::CH_LEFT || z == lec_pkg::CH_DOWN) begin
						moved = 1'b1;
						if (cur != '0) begin
							cur_nx = cur - PW'(1);
						end
					end
				end
				if (!moved && len < LMAX) begin
					plan.op = lec_pkg::OP_INS;
					cur_nx  = cur + PW'(1);
					len_nx  = len + PW'(1);
				end
			end
			if (7'(len_nx) >= eff_cap) begin
				plan.emit  = 1'b1;
				plan.cause = lec_pkg::CAUSE_FULL;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lec_engine.sv
// Line store and edit sequencer for the line editor core.
// Holds the line memory, runs byte moves, inserts and line emission, and the result register.
// Depends on lec_pkg.
`default_nettype none

module lec_engine #(
	parameter int LINE_MAX = 64
) (
	input  var logic                             clk,
	input  var logic                             arst_n,
	input  var logic                             item_acc,
	input  var logic [7:0]                       item_byte,
	input  var lec_pkg::lec_plan_t               plan,
	input  var logic [$clog2(LINE_MAX+1)-1:0]    cur_nx,
	input  var logic [$clog2(LINE_MAX+1)-1:0]    len_nx,
	input  var logic                             esc_nx,
	output logic [$clog2(LINE_MAX+1)-1:0]        cur,
	output logic [$clog2(LINE_MAX+1)-1:0]        len,
	output logic                                 esc,
	output logic                                 busy,
	output logic                                 res_valid,
	input  var logic                             res_stall,
	output lec_pkg::lec_out_t                    res_data
);

	localparam int PW = $clog2(LINE_MAX + 1);
	localparam int AW = $clog2(LINE_MAX);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOVE,
		ST_WR,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [PW-1:0]      cur_q;
	logic [PW-1:0]      len_q;
	logic               esc_q;
	lec_pkg::lec_op_t   op_q;
	logic               emit_q;
	logic [1:0]         cause_q;
	logic [PW-1:0]      n_q;
	logic [PW-1:0]      e_q;
	logic [PW-1:0]      src_q;
	logic [PW-1:0]      dst_q;
	logic [PW-1:0]      cnt_q;
	logic               dir_q;
	logic               pend_q;
	logic [AW-1:0]      wa_q;
	logic [7:0]         wd_q;
	logic               rpend_q;
	logic               lastp_q;
	lec_pkg::lec_out_t  out_q;
	logic               out_vld_q;

	logic [7:0]         mem_q [LINE_MAX];
	logic [7:0]         rdata_q;

	logic               out_free;
	logic               move_done;
	logic               issue;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [7:0]         wdata;
	logic [AW-1:0]      raddr;
	logic [PW-1:0]      shl_start;
	logic [PW-1:0]      shl_cnt;
	state_t             post_st;

	assign cur       = cur_q;
	assign len       = len_q;
	assign esc       = esc_q;
	assign busy      = (state_q != ST_IDLE);
	assign res_valid = out_vld_q;
	assign res_data  = out_q;

	assign out_free  = !out_vld_q || !res_stall;
	assign move_done = (cnt_q == '0) && !pend_q;
	assign issue     = (state_q == ST_EMIT) && (n_q != '0) && !rpend_q
			&& (e_q != n_q) && out_free;
	assign shl_start = cur_q + PW'(plan.skip);
	assign shl_cnt   = (shl_start < len_q) ? (len_q - shl_start) : '0;
	assign post_st   = emit_q ? ST_EMIT : ST_IDLE;

	assign we    = ((state_q == ST_MOVE) && pend_q) || (state_q == ST_WR);
	assign waddr = (state_q == ST_WR) ? wa_q : dst_q[AW-1:0];
	assign wdata = (state_q == ST_WR) ? wd_q : rdata_q;
	assign raddr = (state_q == ST_EMIT) ? e_q[AW-1:0] : src_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_q     <= '0;
			len_q     <= '0;
			esc_q     <= 1'b0;
			op_q      <= lec_pkg::OP_NONE;
			emit_q    <= 1'b0;
			cause_q   <= lec_pkg::CAUSE_NEWLINE;
			n_q       <= '0;
			e_q       <= '0;
			src_q     <= '0;
			dst_q     <= '0;
			cnt_q     <= '0;
			dir_q     <= 1'b0;
			pend_q    <= 1'b0;
			wa_q      <= '0;
			wd_q      <= '0;
			rpend_q   <= 1'b0;
			lastp_q   <= 1'b0;
			out_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_vld_q && !res_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						op_q    <= plan.op;
						emit_q  <= plan.emit;
						cause_q <= plan.cause;
						n_q     <= len_nx;
						e_q     <= '0;
						rpend_q <= 1'b0;
						pend_q  <= 1'b0;
						wa_q    <= cur_q[AW-1:0];
						wd_q    <= item_byte;
						if (plan.emit) begin
							cur_q <= '0;
							len_q <= '0;
							esc_q <= 1'b0;
						end else begin
							cur_q <= cur_nx;
							len_q <= len_nx;
							esc_q <= esc_nx;
						end
						case (plan.op)
							lec_pkg::OP_LF: begin
								wa_q    <= len_q[AW-1:0];
								wd_q    <= lec_pkg::CH_LF;
								state_q <= ST_WR;
							end
							lec_pkg::OP_SHL: begin
								src_q   <= shl_start;
								dir_q   <= 1'b0;
								cnt_q   <= shl_cnt;
								state_q <= ST_MOVE;
							end
							lec_pkg::OP_INS: begin
								src_q   <= len_q - PW'(1);
								dir_q   <= 1'b1;
								cnt_q   <= len_q - cur_q;
								state_q <= ST_MOVE;
							end
							default: begin
								state_q <= plan.emit ? ST_EMIT : ST_IDLE;
							end
						endcase
					end
				end
				ST_MOVE: begin
					if (cnt_q != '0) begin
						dst_q  <= dir_q ? (src_q + PW'(1)) : (src_q - PW'(1));
						src_q  <= dir_q ? (src_q - PW'(1)) : (src_q + PW'(1));
						cnt_q  <= cnt_q - PW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (move_done) begin
						state_q <= (op_q == lec_pkg::OP_INS) ? ST_WR : post_st;
					end
				end
				ST_WR: begin
					state_q <= post_st;
				end
				ST_EMIT: begin
					if (n_q == '0) begin
						if (out_free) begin
							out_q.out_byte    <= '0;
							out_q.byte_valid  <= 1'b0;
							out_q.last        <= 1'b1;
							out_q.end_cause   <= cause_q;
							out_q.line_length <= '0;
							out_vld_q         <= 1'b1;
							state_q           <= ST_IDLE;
						end
					end else if (rpend_q) begin
						out_q.out_byte    <= rdata_q;
						out_q.byte_valid  <= 1'b1;
						out_q.last        <= lastp_q;
						out_q.end_cause   <= cause_q;
						out_q.line_length <= 7'(n_q);
						out_vld_q         <= 1'b1;
						rpend_q           <= 1'b0;
						if (lastp_q) begin
							state_q <= ST_IDLE;
						end
					end else if (issue) begin
						e_q     <= e_q + PW'(1);
						lastp_q <= ((e_q + PW'(1)) == n_q);
						rpend_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/line_editor_with_cursor_core.sv
// Line editor with cursor: top level with configuration registers and channel ports.
// Items are taken only while the engine is idle; a shift moves the line's bytes one by one,
// an insert or line feed then writes one byte, and a line end emits the bytes in order as results.
// The input is stalled during any move, write or emission; a line end holds it until its last
// result is out, result stalls included (an empty line gives one result with no byte).
// Reset: cursor, length and escape clear, capacity 64, quit character 28; memory not cleared.
`default_nettype none

module line_editor_with_cursor_core #(
	parameter int LINE_MAX = 64
) (
	input  var logic                                clk,
	input  var logic                                arst_n,
	input  var logic                                item_valid,
	output logic                                    item_stall,
	input  var lec_pkg::lec_in_t                    item_data,
	output logic                                    res_valid,
	input  var logic                                res_stall,
	output lec_pkg::lec_out_t                       res_data,
	input  var logic                                cfg_valid,
	output logic                                    cfg_ready,
	input  var logic [lec_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  var logic [7:0]                          cfg_data
);

	localparam int PW = $clog2(LINE_MAX + 1);

	logic [6:0]          capacity_q;
	logic [7:0]          quit_q;
	logic                busy;
	logic                item_acc;
	lec_pkg::lec_plan_t  plan;
	logic [PW-1:0]       cur;
	logic [PW-1:0]       len;
	logic                esc;
	logic [PW-1:0]       cur_nx;
	logic [PW-1:0]       len_nx;
	logic                esc_nx;

	assign cfg_ready  = 1'b1;
	assign item_stall = busy;
	assign item_acc   = item_valid && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lec_pkg::CAPACITY_RESET;
			quit_q     <= lec_pkg::QUIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lec_pkg::REG_CAPACITY: capacity_q <= cfg_data[6:0];
				lec_pkg::REG_QUIT:     quit_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lec_decode #(
		.LINE_MAX (LINE_MAX)
	) u_decode (
		.item          (item_data),
		.quit_char     (quit_q),
		.line_capacity (capacity_q),
		.cur           (cur),
		.len           (len),
		.esc           (esc),
		.plan          (plan),
		.cur_nx        (cur_nx),
		.len_nx        (len_nx),
		.esc_nx        (esc_nx)
	);

	lec_engine #(
		.LINE_MAX (LINE_MAX)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_acc  (item_acc),
		.item_byte (item_data.data_byte),
		.plan      (plan),
		.cur_nx    (cur_nx),
		.len_nx    (len_nx),
		.esc_nx    (esc_nx),
		.cur       (cur),
		.len       (len),
		.esc       (esc),
		.busy      (busy),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

`default_nettype wire
